// ----- sv/bilinear_image_scaler_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the bilinear image scaler
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// check under reset-disable
`define BIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds during reset
`define BIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BIS_ASSERT(lbl, prop, msg)
`define BIS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/bis_pkg.sv -----
// ---------------------------------------------------------------------------
// bis_pkg
// Shared constants and types of the bilinear image scaler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bis_pkg;

  localparam int SRC_BITS   = 8;                 // log2 of max source size
  localparam int MAX_SRC    = 1 << SRC_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int WEIGHT_BITS = 8;
  localparam int STEP_W     = SRC_BITS + FRAC_BITS + 1;
  localparam int TGT_W      = 13;
  localparam int MAX_TGT    = 4096;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_TGT_W = 2'd2;
  localparam logic [1:0] REG_TGT_H = 2'd3;

  typedef struct packed {
    logic                   start;
    logic [STEP_W-1:0]      num;
    logic [TGT_W-1:0]       den;
  } div_req_t;

endpackage
`default_nettype wire

// ----- sv/bilinear_image_scaler_top.sv -----
// ---------------------------------------------------------------------------
// bilinear_image_scaler_top
// Bilinear ARGB8888 scaler around a 64K-word source pixel memory.
// ---------------------------------------------------------------------------
// A write word (tuser 0) stores one source pixel if it lies inside the
// source size. A sample word (tuser 1) steps through multiply, position,
// four reads from the source memory (one per cycle, with registered read
// data), a horizontal and a vertical blend. One word is in work at a time;
// a finished pixel waits in the output register while the next word is
// taken. Each register write restarts the step dividers, which hold tready
// low until they finish. Pixels never written read undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_image_scaler_top_macros.svh"
module bilinear_image_scaler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // coord_x[11:0], coord_y[23:12], pixel_in[55:24]
  input  wire logic        s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // pixel_out[31:0], out_x[43:32], out_y[55:44]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int SB = bis_pkg::SRC_BITS;
  localparam int FB = bis_pkg::FRAC_BITS;
  localparam int WB = bis_pkg::WEIGHT_BITS;
  localparam int SW = bis_pkg::STEP_W;
  localparam int PW = SW + 13;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_POS  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_HB   = 3'd4;
  localparam logic [2:0] S_VB   = 3'd5;

  typedef struct packed {
    logic [SB-1:0] i0;
    logic [SB-1:0] i1;
    logic [WB-1:0] f;
  } axis_t;

  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [WB-1:0] f);
    logic [31:0]   r;
    logic [WB:0]   fw;
    logic [WB+9:0] acc;
    fw = (WB+1)'(1 << WB) - {1'b0, f};
    r = '0;
    for (int c = 0; c < 4; c++) begin
      acc = (WB+10)'(a[8*c +: 8]) * (WB+10)'(fw) + (WB+10)'(b[8*c +: 8]) * (WB+10)'(f)
            + (WB+10)'(1 << (WB-1));
      r[8*c +: 8] = acc[WB +: 8];
    end
    return r;
  endfunction

  function automatic axis_t map_axis(input logic [PW-1:0] prod, input logic [8:0] size);
    axis_t         m;
    logic [PW-2:0] t;
    logic [PW-2:0] pos;
    logic [PW-2:0] lim;
    logic [8:0]    nxt;
    t   = prod[PW-1:1];
    pos = (t < (PW-1)'(1 << (FB-1))) ? '0 : t - (PW-1)'(1 << (FB-1));
    lim = (PW-1)'(size - 9'd1) << FB;
    if (pos > lim) pos = lim;
    m.i0 = pos[FB +: SB];
    nxt  = {1'b0, m.i0} + 9'd1;
    m.i1 = (nxt < size) ? nxt[SB-1:0] : m.i0;
    m.f  = pos[FB-WB +: WB];
    return m;
  endfunction

  // configuration
  logic [8:0]  src_w, src_h;
  logic [12:0] tgt_w, tgt_h;
  logic        div_start;
  logic        busy_x, busy_y;
  logic [SW-1:0] step_x, step_y;
  bis_pkg::div_req_t req_x, req_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= 9'd256;
      src_h <= 9'd256;
      tgt_w <= 13'd256;
      tgt_h <= 13'd256;
      div_start <= 1'b0;
    end else begin
      div_start <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          bis_pkg::REG_SRC_W: src_w <= (cfg_data[8:0] == 9'd0) ? 9'd1 :
                               (cfg_data[8:0] > 9'(bis_pkg::MAX_SRC)) ?
                               9'(bis_pkg::MAX_SRC) : cfg_data[8:0];
          bis_pkg::REG_SRC_H: src_h <= (cfg_data[8:0] == 9'd0) ? 9'd1 :
                               (cfg_data[8:0] > 9'(bis_pkg::MAX_SRC)) ?
                               9'(bis_pkg::MAX_SRC) : cfg_data[8:0];
          bis_pkg::REG_TGT_W: tgt_w <= (cfg_data == 13'd0) ? 13'd1 :
                               (cfg_data > 13'(bis_pkg::MAX_TGT)) ?
                               13'(bis_pkg::MAX_TGT) : cfg_data;
          bis_pkg::REG_TGT_H: tgt_h <= (cfg_data == 13'd0) ? 13'd1 :
                               (cfg_data > 13'(bis_pkg::MAX_TGT)) ?
                               13'(bis_pkg::MAX_TGT) : cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign req_x = '{start: div_start, num: SW'(src_w) << FB, den: tgt_w};
  assign req_y = '{start: div_start, num: SW'(src_h) << FB, den: tgt_h};

  bis_div u_div_x (.clk(clk), .rst(rst), .req(req_x), .busy(busy_x), .quo(step_x));
  bis_div u_div_y (.clk(clk), .rst(rst), .req(req_y), .busy(busy_y), .quo(step_y));

  // input fields
  logic [11:0] in_x, in_y;
  logic [31:0] in_pix;
  logic        s_acc;
  assign in_x   = s_tdata[11:0];
  assign in_y   = s_tdata[23:12];
  assign in_pix = s_tdata[55:24];

  logic [2:0] state;
  assign s_tready = (state == S_IDLE) && !div_start && !busy_x && !busy_y;
  assign s_acc    = s_tvalid && s_tready;

  // source memory, pixel (x,y) at {y,x}
  logic [31:0]     mem [0:(1 << (2*SB))-1];
  logic [31:0]     rdata;
  logic [2*SB-1:0] raddr;
  logic            wr_en;
  assign wr_en = s_acc && !s_tuser && ({3'b0, in_x} < {3'b0, src_w})
                 && ({3'b0, in_y} < {3'b0, src_h});

  always_ff @(posedge clk) begin
    if (wr_en) mem[{in_y[SB-1:0], in_x[SB-1:0]}] <= in_pix;
    rdata <= mem[raddr];
  end

  // sample datapath
  logic [11:0]   cx, cy;
  logic [PW-1:0] prod_x, prod_y;
  axis_t         ax, ay;
  logic [2:0]    rd_cnt;
  logic [31:0]   nb [0:3];
  logic [31:0]   top, bot;
  logic          out_valid;
  logic [31:0]   out_pix;
  logic [11:0]   out_x, out_y;

  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    raddr = {ay.i0, ax.i0};
      2'd1:    raddr = {ay.i0, ax.i1};
      2'd2:    raddr = {ay.i1, ax.i0};
      default: raddr = {ay.i1, ax.i1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_acc && s_tuser) begin
            cx    <= in_x;
            cy    <= in_y;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_x <= PW'({cx, 1'b1}) * PW'(step_x);
          prod_y <= PW'({cy, 1'b1}) * PW'(step_y);
          state  <= S_POS;
        end
        S_POS: begin
          ax     <= map_axis(prod_x, src_w);
          ay     <= map_axis(prod_y, src_h);
          rd_cnt <= '0;
          state  <= S_RD;
        end
        S_RD: begin
          // address k issued at count k, its data lands one count later
          if (rd_cnt != 3'd0) nb[rd_cnt[1:0] - 2'd1] <= rdata;
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt == 3'd4) state <= S_HB;
        end
        S_HB: begin
          top   <= blend(nb[0], nb[1], ax.f);
          bot   <= blend(nb[2], nb[3], ax.f);
          state <= S_VB;
        end
        S_VB: begin
          if (!out_valid || m_tready) begin
            out_pix   <= blend(top, bot, ay.f);
            out_x     <= cx;
            out_y     <= cy;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_y, out_x, out_pix};

  `BIS_ASSERT_ALWAYS(a_ready_idle, s_tready |-> (state == S_IDLE), "tready outside idle")
  `BIS_ASSERT(a_sample_start, (s_acc && s_tuser) |=> (state == S_MUL), "sample not started")
  `BIS_ASSERT(a_div_block, (busy_x || busy_y) |-> !s_tready, "word taken during divide")
  `BIS_ASSERT(a_vb_hold, (state == S_VB && out_valid && !m_tready) |=> (state == S_VB),
              "result lost while output stalled")

endmodule
`default_nettype wire

// ----- sv/bis_div.sv -----
// ---------------------------------------------------------------------------
// bis_div
// Restoring divider, one quotient bit per cycle; holds the last quotient.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bis_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bis_pkg::div_req_t         req,
  output logic                           busy,
  output logic [bis_pkg::STEP_W-1:0]     quo
);

  localparam int CNT_W = $clog2(bis_pkg::STEP_W + 1);

  logic [bis_pkg::STEP_W-1:0] sh;
  logic [bis_pkg::TGT_W-1:0]  den;
  logic [bis_pkg::TGT_W-1:0]  rem;
  logic [CNT_W-1:0]           cnt;
  logic [bis_pkg::TGT_W:0]    trial;
  logic                       qbit;
  logic [bis_pkg::TGT_W:0]    rem_next;

  always_comb begin
    trial = {rem, sh[bis_pkg::STEP_W-1]};
    qbit  = (trial >= {1'b0, den});
    rem_next = qbit ? (trial - {1'b0, den}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      quo  <= bis_pkg::STEP_RESET;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(bis_pkg::STEP_W);
      sh   <= req.num;
      den  <= req.den;
      rem  <= '0;
    end else if (busy) begin
      // numerator shifts out the top while quotient bits shift in
      sh  <= {sh[bis_pkg::STEP_W-2:0], qbit};
      rem <= rem_next[bis_pkg::TGT_W-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        quo  <= {sh[bis_pkg::STEP_W-2:0], qbit};
      end
    end
  end

endmodule
`default_nettype wire

// ----- verif/bilinear_image_scaler_top_test.sv -----
// ---------------------------------------------------------------------------
// bilinear_image_scaler_top_test
// Self-checking test of the bilinear scaler: source images are written
// pixel by pixel, output pixels are sampled under many source and target
// sizes, and every result word is checked against an in-bench predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module bilinear_image_scaler_top_test;

  typedef enum logic {REQ_WRITE = 1'b0, REQ_SAMPLE = 1'b1} req_e;

  typedef struct {
    logic [31:0] pixel;
    logic [11:0] x;
    logic [11:0] y;
  } scaled_pixel_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = bis_pkg::REG_SRC_W;
  logic [12:0] cfg_data = '0;

  bilinear_image_scaler_top i_dut (.*);

  // shadow of the block
  logic [31:0] src_mem [0:bis_pkg::MAX_SRC*bis_pkg::MAX_SRC-1];
  int src_w = 256, src_h = 256, tgt_w = 256, tgt_h = 256;
  scaled_pixel_t pending_pixels[$];

  int  fail_count = 0;
  int  n_writes = 0, n_samples = 0, n_checked = 0, n_settings = 0;
  int  cycles = 0;
  bit  no_idle = 0;
  int  rx_wait = 0;
  int  rx_draw;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int clamp_size(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void map_axis(int coord, int src, int tgt,
                                   output int i0, output int i1, output int f);
    longint step, t, pos, lim;
    step = (longint'(src) << bis_pkg::FRAC_BITS) / tgt;
    t = ((longint'(coord) * 2 + 1) * step) >> 1;
    pos = (t < (64'd1 << (bis_pkg::FRAC_BITS - 1))) ? 0 :
          t - (64'd1 << (bis_pkg::FRAC_BITS - 1));
    lim = longint'(src - 1) << bis_pkg::FRAC_BITS;
    if (pos > lim) pos = lim;
    i0 = int'(pos >> bis_pkg::FRAC_BITS);
    i1 = (i0 + 1 < src) ? i0 + 1 : i0;
    f = int'((pos >> (bis_pkg::FRAC_BITS - bis_pkg::WEIGHT_BITS)) &
             ((1 << bis_pkg::WEIGHT_BITS) - 1));
  endfunction

  function automatic logic [31:0] blend_argb(logic [31:0] a, logic [31:0] b, int f);
    logic [31:0] r;
    int ca, cb;
    for (int c = 0; c < 4; c++) begin
      ca = a[c*8 +: 8];
      cb = b[c*8 +: 8];
      r[c*8 +: 8] = 8'((ca * ((1 << bis_pkg::WEIGHT_BITS) - f) + cb * f +
                        (1 << (bis_pkg::WEIGHT_BITS - 1))) >> bis_pkg::WEIGHT_BITS);
    end
    return r;
  endfunction

  function automatic logic [31:0] scaled_pixel_at(int x, int y);
    int x0, x1, fx, y0, y1, fy;
    logic [31:0] top, bot;
    map_axis(x, src_w, tgt_w, x0, x1, fx);
    map_axis(y, src_h, tgt_h, y0, y1, fy);
    top = blend_argb(src_mem[y0*bis_pkg::MAX_SRC + x0], src_mem[y0*bis_pkg::MAX_SRC + x1], fx);
    bot = blend_argb(src_mem[y1*bis_pkg::MAX_SRC + x0], src_mem[y1*bis_pkg::MAX_SRC + x1], fx);
    return blend_argb(top, bot, fy);
  endfunction

  // result side: random stall per word, checked against oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        scaled_pixel_t e;
        e = pending_pixels.pop_front();
        if (m_tdata[31:0] !== e.pixel) begin
          $error("pixel_out expected %h got %h", e.pixel, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[43:32] !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, m_tdata[43:32]);
          fail_count++;
        end
        if (m_tdata[55:44] !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, m_tdata[55:44]);
          fail_count++;
        end
      end
      n_checked++;
      rx_draw = no_idle ? 0 : $urandom_range(0, 10);
      rx_wait <= rx_draw;
      m_tready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // valid stays high into the next word when no gap is drawn
  task automatic send_word(req_e kind, int x, int y, logic [31:0] pix);
    int gap;
    scaled_pixel_t e;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {pix, 12'(y), 12'(x)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == REQ_WRITE) begin
      n_writes++;
      if (x < src_w && y < src_h) src_mem[y*bis_pkg::MAX_SRC + x] = pix;
    end else begin
      n_samples++;
      e.pixel = scaled_pixel_at(x, y);
      e.x = 12'(x);
      e.y = 12'(y);
      pending_pixels.push_back(e);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 13'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bis_pkg::REG_SRC_W: src_w = clamp_size(value & 'h1FF, bis_pkg::MAX_SRC);
      bis_pkg::REG_SRC_H: src_h = clamp_size(value & 'h1FF, bis_pkg::MAX_SRC);
      bis_pkg::REG_TGT_W: tgt_w = clamp_size(value & 'h1FFF, bis_pkg::MAX_TGT);
      default:            tgt_h = clamp_size(value & 'h1FFF, bis_pkg::MAX_TGT);
    endcase
  endtask

  // new sizes, then a full source image so no sample reads an unset word
  task automatic set_sizes(int sw, int sh, int tw, int th);
    drain();
    write_reg(bis_pkg::REG_SRC_W, sw);
    write_reg(bis_pkg::REG_SRC_H, sh);
    write_reg(bis_pkg::REG_TGT_W, tw);
    write_reg(bis_pkg::REG_TGT_H, th);
    n_settings++;
    for (int y = 0; y < src_h; y++)
      for (int x = 0; x < src_w; x++)
        send_word(REQ_WRITE, x, y, ($urandom_range(0, 7) == 0) ?
                  {32{1'($urandom)}} : $urandom);
  endtask

  task automatic test_directed();
    set_sizes(4, 3, 7, 5);
    send_word(REQ_SAMPLE, 0, 0, 0);
    send_word(REQ_SAMPLE, 6, 4, 0);
    send_word(REQ_SAMPLE, 3, 2, '1);
    // outside the target, clamps at the last column and row
    send_word(REQ_SAMPLE, 4095, 4095, 0);
    send_word(REQ_SAMPLE, 7, 0, 0);
    send_word(REQ_WRITE, 0, 0, 32'hFFFFFFFF);
    send_word(REQ_WRITE, 3, 2, 32'h00000000);
    send_word(REQ_WRITE, 1, 1, 32'hFF00FF00);
    // writes outside the source are dropped
    send_word(REQ_WRITE, 4, 0, 32'h12345678);
    send_word(REQ_WRITE, 0, 3, 32'h9ABCDEF0);
    send_word(REQ_WRITE, 4095, 4095, 32'hDEADBEEF);
    for (int i = 0; i < 7; i++) send_word(REQ_SAMPLE, i, i % 5, 0);
    // zero sizes read as one
    set_sizes(0, 0, 0, 0);
    send_word(REQ_SAMPLE, 0, 0, 0);
    send_word(REQ_SAMPLE, 4095, 0, 0);
    // oversized source and target saturate
    set_sizes(511, 1, 8191, 1);
    send_word(REQ_SAMPLE, 4095, 0, 0);
    send_word(REQ_SAMPLE, 2048, 0, 0);
    set_sizes(1, 256, 1, 4096);
    send_word(REQ_SAMPLE, 0, 4095, 0);
    send_word(REQ_SAMPLE, 0, 0, 0);
    set_sizes(256, 1, 1, 1);
    send_word(REQ_SAMPLE, 0, 0, 0);
  endtask

  task automatic test_random();
    int sw, sh, tw, th, roll;
    for (int p = 0; p < 14; p++) begin
      no_idle = (p % 4 == 3);
      sw = $urandom_range(1, 8);
      sh = $urandom_range(1, 8);
      tw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 40);
      th = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 40);
      if (p == 5) begin sw = 16; sh = 2; tw = 4096; th = 1; end
      if (p == 9) begin sw = 2; sh = 16; tw = 1; th = 4096; end
      set_sizes(sw, sh, tw, th);
      for (int i = 0; i < 45; i++) begin
        roll = $urandom_range(0, 9);
        if (roll < 6)
          send_word(REQ_SAMPLE, $urandom_range(0, tgt_w - 1),
                    $urandom_range(0, tgt_h - 1), $urandom);
        else if (roll < 7)
          send_word(REQ_SAMPLE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom);
        else if (roll < 9)
          send_word(REQ_WRITE, $urandom_range(0, src_w - 1),
                    $urandom_range(0, src_h - 1), $urandom);
        else
          send_word(REQ_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom);
      end
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    $display("covered %0d size settings: %0d pixel writes, %0d samples, %0d words checked",
             n_settings, n_writes, n_samples, n_checked);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
